// ===== src/mppe_rx_coherency_tracker_top_macros.svh =====
// Assertion helpers shared by the tracker RTL.
// Both forms sample on clk and are held off while rst_n is low.
`ifndef MPPE_RX_COHERENCY_TRACKER_TOP_MACROS_SVH
`define MPPE_RX_COHERENCY_TRACKER_TOP_MACROS_SVH

// Same-cycle implication
`define MRXCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tracker assertion failed");

// Next-cycle implication
`define MRXCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker assertion failed");

`endif

// ===== src/mppe_rxct_pkg.sv =====
`default_nettype none
package mppe_rxct_pkg;

  // Configuration register indexes
  localparam logic CFG_STATEFUL_MODE = 1'b0;
  localparam logic CFG_SANITY_LIMIT  = 1'b1;

  localparam logic [15:0] SANITY_LIMIT_RST = 16'd1600;
  localparam logic [11:0] EXPECTED_RST     = 12'hFFF;
  localparam logic [15:0] HEADER_LENGTH    = 16'd2;
  localparam logic [11:0] COUNT_HALF       = 12'd2048;
  localparam logic [7:0]  FLAG_LOW_BYTE    = 8'hFF;
  localparam logic [6:0]  HEADER_PENALTY   = 7'd100;
  localparam logic [6:0]  LATE_PENALTY     = 7'd1;
  localparam logic [15:0] SCORE_MAX        = 16'hFFFF;
  localparam logic [11:0] REKEY_MAX        = 12'd2048;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT    = 2'd0,
    VERDICT_DISCARD   = 2'd1,
    VERDICT_RESET_REQ = 2'd2,
    VERDICT_SANITY    = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [15:0] packet_length;
    logic        encrypted_bit;
    logic        flushed_bit;
    logic [11:0] coherency_count;
  } header_t;

  typedef struct packed {
    logic [11:0] expected_count;
    logic        discard_mode;
    logic [15:0] error_score;
  } track_state_t;

  typedef struct packed {
    logic        stateful_mode;
    logic [15:0] sanity_limit;
  } track_cfg_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [11:0] rekey_count;
    logic        close_link;
  } result_t;

endpackage
`default_nettype wire

// ===== src/mppe_rx_coherency_tracker_top.sv =====
`default_nettype none
// MPPE receive coherency tracker.
// Input channel (in_*): one received MPPE header per transfer: packet length,
//   encrypted bit D, flushed bit A and 12-bit coherency count.
// Result channel (out_*): one result per header: verdict, number of key
//   updates owed to the key engine, and a close-link flag on sanity drops.
// Configuration (cfg_*): index 0 stateful_mode, index 1 sanity_limit; write
//   only while no header is in flight.
// Pipeline: a taken header goes to the header register, then to the result
//   register, where its result is valid and waits while out_stall holds it.
//   Throughput: one header per cycle while no result is stalled; the tracking
//   state (expected count, discard flag, error score) updates in the same
//   cycle the checked header moves to the result register.
// Stall: while out_stall holds a waiting result, the header register keeps
//   its item and in_stall rises once it is occupied; nothing is dropped.
// Reset: synchronous on rst_n low; both channel registers empty, expected
//   count all ones, discard off, score 0, stateless mode, limit 1600.
module mppe_rx_coherency_tracker_top
  import mppe_rxct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_packet_length,
  input  wire logic        in_encrypted_bit,
  input  wire logic        in_flushed_bit,
  input  wire logic [11:0] in_coherency_count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_verdict,
  output logic [11:0]      out_rekey_count,
  output logic             out_close_link,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);

`include "mppe_rx_coherency_tracker_top_macros.svh"

  track_cfg_t   cfg_r;
  track_state_t state_r;
  track_state_t state_nxt;
  header_t      hdr_r;
  logic         hdr_valid_r;
  result_t      res_r;
  result_t      res_nxt;
  logic         out_valid_r;
  logic         advance;
  logic         in_accept;

  // Move the header to the result register when it is free or being drained
  assign advance   = hdr_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = hdr_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  mppe_rxct_eval u_eval (
    .hdr (hdr_r),
    .cur (state_r),
    .cfg (cfg_r),
    .res (res_nxt),
    .nxt (state_nxt)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stateful_mode <= 1'b0;
      cfg_r.sanity_limit  <= SANITY_LIMIT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_STATEFUL_MODE: cfg_r.stateful_mode <= cfg_wdata[0];
        CFG_SANITY_LIMIT:  cfg_r.sanity_limit  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Header register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_valid_r <= 1'b0;
    end else if (in_accept) begin
      hdr_valid_r <= 1'b1;
    end else if (advance) begin
      hdr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hdr_r.packet_length   <= in_packet_length;
      hdr_r.encrypted_bit   <= in_encrypted_bit;
      hdr_r.flushed_bit     <= in_flushed_bit;
      hdr_r.coherency_count <= in_coherency_count;
    end
  end

  // Tracking state: advance with each checked header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.expected_count <= EXPECTED_RST;
      state_r.discard_mode   <= 1'b0;
      state_r.error_score    <= 16'd0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_verdict     = res_r.verdict;
  assign out_rekey_count = res_r.rekey_count;
  assign out_close_link  = res_r.close_link;

  // Close-link only comes with a sanity drop
  `MRXCT_ASSERT_IMP(a_close_on_sanity, out_valid_r && res_r.close_link,
                    res_r.verdict == VERDICT_SANITY)
  // Dropped packets owe no rekeys
  `MRXCT_ASSERT_IMP(a_no_rekey_on_drop, out_valid_r && (res_r.verdict != VERDICT_ACCEPT),
                    res_r.rekey_count == 12'd0)
  // Rekey count stays within range
  `MRXCT_ASSERT_IMP(a_rekey_range, out_valid_r, res_r.rekey_count <= REKEY_MAX)
  // Entering discard is reported as a reset request
  `MRXCT_ASSERT_IMP(a_discard_entry, $rose(state_r.discard_mode),
                    out_valid_r && (res_r.verdict == VERDICT_RESET_REQ))
  // Tracking state moves only when a header is checked
  `MRXCT_ASSERT_NXT(a_state_hold, !advance, $stable(state_r))

endmodule
`default_nettype wire

// ===== src/mppe_rxct_eval.sv =====
`default_nettype none
// Check one header against the tracking state; produce the result and next state.
module mppe_rxct_eval
  import mppe_rxct_pkg::*;
(
  input  header_t      hdr,
  input  track_state_t cur,
  input  track_cfg_t   cfg,
  output result_t      res,
  output track_state_t nxt
);

  logic        header_err;
  logic [11:0] cnt_delta;
  logic        late;
  logic [11:0] exp_inc;
  logic [3:0]  flag_gap;
  logic [6:0]  penalty;
  logic [16:0] score_sum;
  logic [15:0] score_sat;

  // Header sanity checks
  assign header_err = (hdr.packet_length < HEADER_LENGTH) || !hdr.encrypted_bit ||
                      (!cfg.stateful_mode && !hdr.flushed_bit) ||
                      (cfg.stateful_mode && (hdr.coherency_count[7:0] == FLAG_LOW_BYTE) &&
                       !hdr.flushed_bit);

  // Count distance and late test, modulo the count space
  assign cnt_delta = hdr.coherency_count - cur.expected_count;
  assign late      = cnt_delta > COUNT_HALF;
  assign exp_inc   = cur.expected_count + 12'd1;
  assign flag_gap  = hdr.coherency_count[11:8] - cur.expected_count[11:8];

  // Saturating score add for a sanity drop
  assign penalty   = header_err ? HEADER_PENALTY : LATE_PENALTY;
  assign score_sum = {1'b0, cur.error_score} + {10'd0, penalty};
  assign score_sat = score_sum[16] ? SCORE_MAX : score_sum[15:0];

  always_comb begin
    nxt             = cur;
    res.verdict     = VERDICT_ACCEPT;
    res.rekey_count = 12'd0;
    res.close_link  = 1'b0;
    if (header_err || (!cfg.stateful_mode && late)) begin
      // Sanity drop
      nxt.error_score = score_sat;
      res.verdict     = VERDICT_SANITY;
      res.close_link  = (score_sat >= cfg.sanity_limit);
    end else if (!cfg.stateful_mode) begin
      // Stateless: one rekey per count step
      res.rekey_count    = cnt_delta;
      nxt.expected_count = hdr.coherency_count;
      nxt.error_score    = {1'b0, cur.error_score[15:1]};
    end else if (!cur.discard_mode) begin
      nxt.expected_count = exp_inc;
      if (hdr.coherency_count != exp_inc) begin
        // Loss detected: enter discard, ask for reset
        nxt.discard_mode = 1'b1;
        res.verdict      = VERDICT_RESET_REQ;
      end else begin
        res.rekey_count = {11'd0, hdr.flushed_bit};
        nxt.error_score = {1'b0, cur.error_score[15:1]};
      end
    end else if (!hdr.flushed_bit) begin
      // Still waiting for a flushed packet
      res.verdict = VERDICT_DISCARD;
    end else begin
      // Recover: one rekey per missed flag packet plus one for the flush
      res.rekey_count    = {8'd0, flag_gap} + 12'd1;
      nxt.discard_mode   = 1'b0;
      nxt.expected_count = hdr.coherency_count;
      nxt.error_score    = {1'b0, cur.error_score[15:1]};
    end
  end

endmodule
`default_nettype wire
